[hw/rtl/bsl_pkg.sv]
// shared constants, request and status codes, controller states and command and status structs
`timescale 1ns / 1ps
`default_nettype none

package bsl_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    localparam int REQ_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int RDATA_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REM_LAST  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_AT    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DECODE  = 5'b00010,
        ST_SHIFT   = 5'b00100,
        ST_RD_WAIT = 5'b01000,
        ST_DONE    = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_req;
        logic decode;
        logic ins_front;
        logic ins_back;
        logic dec_count;
        logic shift_start;
        logic shift_step;
        logic rd_issue;
        logic rd_capture;
        logic finish;
    } bsl_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic             req_ok;
        logic             shift_needed;
        logic             shift_more;
    } bsl_sts_t;

endpackage

`default_nettype wire

[hw/rtl/bounded_sequence_list.sv]
// top level of the bounded sequence list: stream ports, controller and datapath
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | value[31:0], position[35:32], zero [39:36]  | req_type[2:0]
//  m_      | out | read_data[31:0], status[33:32],             | -
//          |     | count[38:34], empty_res[39]                 |
//
// insert and remove-last go from decode to done; read passes a read wait state between them
// remove-at-index adds a shift state when entries lie behind the removed position:
// one ring memory port pair moves one entry per cycle while the gap closes
// a new request is taken once the previous result sits in the output register
// aresetn is synchronous: the store is empty and the front pointer is zero
// a stalled result holds the output register; the next request runs to its done state
// and waits there
`timescale 1ns / 1ps
`default_nettype none

module bounded_sequence_list #(
    parameter int DEPTH  = bsl_pkg::DEPTH_DEF,
    parameter int DATA_W = bsl_pkg::DATA_W_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [bsl_pkg::S_TDATA_W-1:0]     s_tdata,  // value, position, pad
    input  wire [bsl_pkg::REQ_W-1:0]         s_tuser,  // req_type
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [bsl_pkg::M_TDATA_W-1:0]    m_tdata   // read_data, status, count, empty_res
);

    bsl_pkg::bsl_cmd_t                cmd;
    bsl_pkg::bsl_sts_t                sts;
    logic signed [bsl_pkg::RDATA_W-1:0] read_data;
    logic [bsl_pkg::STATUS_W-1:0]     status;
    logic [bsl_pkg::COUNT_W-1:0]      count;
    logic                             empty_res;

    bsl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsl_dp #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .req_type  (s_tuser),
        .value     (s_tdata[bsl_pkg::VALUE_W-1:0]),
        .position  (s_tdata[bsl_pkg::VALUE_W +: bsl_pkg::POS_W]),
        .read_data (read_data),
        .status    (status),
        .count     (count),
        .empty_res (empty_res)
    );

    assign m_tdata = {empty_res, count, status, read_data};

endmodule

`default_nettype wire

[hw/rtl/bsl_ctrl.sv]
// controller state machine: sequences decode, shift, read and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module bsl_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    input  bsl_pkg::bsl_sts_t   sts,
    output bsl_pkg::bsl_cmd_t   cmd
);

    bsl_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == bsl_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            bsl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = bsl_pkg::ST_DECODE;
                end
            end
            bsl_pkg::ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = bsl_pkg::ST_DONE;
                if (sts.req_ok) begin
                    case (sts.kind)
                        bsl_pkg::REQ_INS_FRONT: cmd.ins_front = 1'b1;
                        bsl_pkg::REQ_INS_BACK:  cmd.ins_back  = 1'b1;
                        bsl_pkg::REQ_REM_LAST:  cmd.dec_count = 1'b1;
                        bsl_pkg::REQ_REM_AT: begin
                            if (sts.shift_needed) begin
                                cmd.shift_start = 1'b1;
                                state_next      = bsl_pkg::ST_SHIFT;
                            end else begin
                                cmd.dec_count = 1'b1;
                            end
                        end
                        bsl_pkg::REQ_READ: begin
                            cmd.rd_issue = 1'b1;
                            state_next   = bsl_pkg::ST_RD_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            bsl_pkg::ST_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (!sts.shift_more) begin
                    cmd.dec_count = 1'b1;
                    state_next    = bsl_pkg::ST_DONE;
                end
            end
            bsl_pkg::ST_RD_WAIT: begin
                cmd.rd_capture = 1'b1;
                state_next     = bsl_pkg::ST_DONE;
            end
            bsl_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = bsl_pkg::ST_IDLE;
                end
            end
            default: state_next = bsl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bsl_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bsl_dp.sv]
// datapath: entry ring memory, front pointer, count, shift index and result registers
`timescale 1ns / 1ps
`default_nettype none

module bsl_dp #(
    parameter int DEPTH  = bsl_pkg::DEPTH_DEF,
    parameter int DATA_W = bsl_pkg::DATA_W_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  bsl_pkg::bsl_cmd_t                 cmd,
    output bsl_pkg::bsl_sts_t                 sts,
    input  wire [bsl_pkg::REQ_W-1:0]          req_type,
    input  wire signed [bsl_pkg::VALUE_W-1:0] value,
    input  wire [bsl_pkg::POS_W-1:0]          position,
    output logic signed [bsl_pkg::RDATA_W-1:0] read_data,
    output logic [bsl_pkg::STATUS_W-1:0]      status,
    output logic [bsl_pkg::COUNT_W-1:0]       count,
    output logic                              empty_res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = CW + 1;
    localparam int SW   = IW + 1;
    localparam int CMPW = (CW > bsl_pkg::POS_W) ? CW : bsl_pkg::POS_W;
    localparam int XW   = (CW > bsl_pkg::COUNT_W) ? CW : bsl_pkg::COUNT_W;
    localparam int VW   = (DATA_W > bsl_pkg::VALUE_W) ? DATA_W : bsl_pkg::VALUE_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_q;

    logic [bsl_pkg::REQ_W-1:0]    req_type_reg;
    logic [DATA_W-1:0]            word_reg;
    logic [bsl_pkg::POS_W-1:0]    pos_reg;
    logic [bsl_pkg::STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]            rdata_reg;
    logic [CW-1:0]                k_reg, k_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                fp_reg, fp_next;

    logic [bsl_pkg::RDATA_W-1:0]  rd_out_reg;
    logic [bsl_pkg::STATUS_W-1:0] status_out_reg;
    logic [bsl_pkg::COUNT_W-1:0]  count_out_reg;
    logic                         empty_out_reg;

    logic [VW-1:0]                value_x;
    logic [VW-1:0]                rdata_x;
    logic [XW-1:0]                count_x;
    logic [CMPW-1:0]              pos_cmp, cnt_cmp;
    logic [IW-1:0]                pos_i, k_i, cnt_i, rd_idx;
    logic [AW-1:0]                fp_dec, rd_addr, wr_addr;
    logic [DATA_W-1:0]            wr_data;
    logic                         we, re, full, store_empty;
    logic [bsl_pkg::STATUS_W-1:0] stat;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [IW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(idx);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign value_x     = VW'($unsigned(value));
    assign pos_cmp     = CMPW'(pos_reg);
    assign cnt_cmp     = CMPW'(count_reg);
    assign pos_i       = IW'(pos_cmp);
    assign k_i         = IW'(k_reg);
    assign cnt_i       = IW'(count_reg);
    assign full        = (count_reg == CW'(DEPTH));
    assign store_empty = (count_reg == '0);
    assign fp_dec      = (fp_reg == '0) ? AW'(DEPTH - 1) : fp_reg - AW'(1);

    always_comb begin
        case (req_type_reg)
            bsl_pkg::REQ_INS_FRONT,
            bsl_pkg::REQ_INS_BACK: stat = full ? bsl_pkg::STS_FULL : bsl_pkg::STS_OK;
            bsl_pkg::REQ_REM_LAST: stat = store_empty ? bsl_pkg::STS_EMPTY : bsl_pkg::STS_OK;
            bsl_pkg::REQ_REM_AT,
            bsl_pkg::REQ_READ: begin
                if (store_empty) begin
                    stat = bsl_pkg::STS_EMPTY;
                end else if (pos_cmp >= cnt_cmp) begin
                    stat = bsl_pkg::STS_RANGE;
                end else begin
                    stat = bsl_pkg::STS_OK;
                end
            end
            default: stat = bsl_pkg::STS_OK;
        endcase
    end

    assign sts.kind         = req_type_reg;
    assign sts.req_ok       = (stat == bsl_pkg::STS_OK);
    assign sts.shift_needed = (pos_i + IW'(1)) < cnt_i;
    assign sts.shift_more   = (k_i + IW'(2)) < cnt_i;

    // memory port addressing
    always_comb begin
        if (cmd.shift_start) begin
            rd_idx = pos_i + IW'(1);
        end else if (cmd.shift_step) begin
            rd_idx = k_i + IW'(2);
        end else begin
            rd_idx = pos_i;
        end
        rd_addr = slot_of(fp_reg, rd_idx);
        re      = cmd.shift_start || cmd.rd_issue || (cmd.shift_step && sts.shift_more);

        if (cmd.ins_front) begin
            wr_addr = fp_dec;
        end else if (cmd.ins_back) begin
            wr_addr = slot_of(fp_reg, cnt_i);
        end else begin
            wr_addr = slot_of(fp_reg, k_i);
        end
        wr_data = cmd.shift_step ? mem_q : word_reg;
        we      = cmd.ins_front || cmd.ins_back || cmd.shift_step;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            mem_q <= mem[rd_addr];
        end
    end

    always_comb begin
        count_next = count_reg;
        fp_next    = fp_reg;
        k_next     = k_reg;
        if (cmd.ins_front) begin
            fp_next    = fp_dec;
            count_next = count_reg + CW'(1);
        end
        if (cmd.ins_back) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.dec_count) begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.shift_start) begin
            k_next = pos_i[CW-1:0];
        end
        if (cmd.shift_step) begin
            k_next = k_reg + CW'(1);
        end
        // an emptied store restarts at slot zero
        if (cmd.finish && store_empty) begin
            fp_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            fp_reg    <= '0;
        end else begin
            count_reg <= count_next;
            fp_reg    <= fp_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (cmd.load_req) begin
            req_type_reg <= req_type;
            word_reg     <= value_x[DATA_W-1:0];
            pos_reg      <= position;
        end
        if (cmd.decode) begin
            status_reg <= stat;
            rdata_reg  <= '0;
        end
        if (cmd.rd_capture) begin
            rdata_reg <= mem_q;
        end
    end

    assign rdata_x = VW'(rdata_reg);
    assign count_x = XW'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            rd_out_reg     <= rdata_x[bsl_pkg::RDATA_W-1:0];
            status_out_reg <= status_reg;
            count_out_reg  <= count_x[bsl_pkg::COUNT_W-1:0];
            empty_out_reg  <= store_empty;
        end
    end

    assign read_data = rd_out_reg;
    assign status    = status_out_reg;
    assign count     = count_out_reg;
    assign empty_res = empty_out_reg;

endmodule

`default_nettype wire

[hw/rtl/bsl_checker.sv]
// port-level checker for the bounded sequence list and its bind
`timescale 1ns / 1ps
`default_nettype none

module bsl_checker #(
    parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [bsl_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic        s_beat;
    logic [1:0]  st;
    logic [4:0]  cnt;

    assign s_beat = s_tvalid && s_tready;
    assign st     = m_tdata[33:32];
    assign cnt    = m_tdata[38:34];

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39] == (cnt == 5'd0)) || (DEPTH > 31))
        else $error("empty flag disagrees with count");

    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != bsl_pkg::STS_OK |-> m_tdata[31:0] == '0)
        else $error("read data nonzero on failed request");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_tready)
        else $error("second request taken while one is in progress");

endmodule

bind bounded_sequence_list bsl_checker #(.DEPTH(DEPTH)) u_bsl_checker (.*);

`default_nettype wire

[test/bounded_sequence_list_test.sv]
// self-checking testbench for the bounded sequence list: directed and random stream traffic vs a queue model
`timescale 1ns / 1ps

module bounded_sequence_list_test;
    import bsl_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 925;
    localparam int TAIL_ITEMS   = 100;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [REQ_W-1:0]          kind;
        logic signed [VALUE_W-1:0] word;
        logic [POS_W-1:0]          pos;
    } list_req_t;

    // same layout as m_tdata, msb first
    typedef struct packed {
        logic                      empty;
        logic [COUNT_W-1:0]        count;
        logic [STATUS_W-1:0]       status;
        logic signed [RDATA_W-1:0] rdata;
    } list_result_t;

    typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} traffic_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // value, position, pad
    logic [REQ_W-1:0]       s_tuser  = '0;  // req_type
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // read_data, status, count, empty_res

    list_req_t              pending_reqs[$];
    list_result_t           expected_responses[$];
    logic signed [31:0]     list_words[$];
    list_req_t              offered;
    list_result_t           want;
    list_result_t           got;
    int                     gen_count    = 0;
    int                     tx_gap       = 0;
    int                     rx_gap       = 0;
    int                     hold_left    = 0;
    bit                     hold_done    = 1'b0;
    bit                     tail_phase   = 1'b0;
    int                     results_seen = 0;
    int                     mismatches   = 0;
    int                     cycle_count  = 0;

    bounded_sequence_list DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic list_result_t predict_response(input list_req_t r);
        list_result_t res;
        res.rdata  = '0;
        res.status = STS_OK;
        case (r.kind)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (list_words.size() >= DEPTH)
                    res.status = STS_FULL;
                else if (r.kind == REQ_INS_FRONT)
                    list_words.push_front(r.word);
                else
                    list_words.push_back(r.word);
            end
            REQ_REM_LAST: begin
                if (list_words.size() == 0)
                    res.status = STS_EMPTY;
                else
                    void'(list_words.pop_back());
            end
            REQ_REM_AT: begin
                if (list_words.size() == 0)
                    res.status = STS_EMPTY;
                else if (r.pos >= list_words.size())
                    res.status = STS_RANGE;
                else
                    list_words.delete(r.pos);
            end
            REQ_READ: begin
                if (list_words.size() == 0)
                    res.status = STS_EMPTY;
                else if (r.pos >= list_words.size())
                    res.status = STS_RANGE;
                else
                    res.rdata = list_words[r.pos];
            end
            default: ;
        endcase
        res.count = COUNT_W'(list_words.size());
        res.empty = (list_words.size() == 0);
        return res;
    endfunction

    // gen_count tracks the fill level only to steer the random traffic
    task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [31:0] word,
                             input logic [POS_W-1:0] pos);
        list_req_t r;
        r.kind = kind;
        r.word = word;
        r.pos  = pos;
        pending_reqs.push_back(r);
        case (kind)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (gen_count < DEPTH) gen_count++;
            end
            REQ_REM_LAST: begin
                if (gen_count > 0) gen_count--;
            end
            REQ_REM_AT: begin
                if (gen_count > 0 && pos < gen_count) gen_count--;
            end
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                   input logic [31:0] act_val);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
    endtask

    // stimulus and end of run
    initial begin
        traffic_t         traffic;
        int               traffic_left;
        int               ins_pct;
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        logic [31:0]      word;

        // empty store, empty takes priority over range
        queue_req(REQ_READ, 32'h1234_5678, 4'd0);
        queue_req(REQ_REM_LAST, 32'h0, 4'd0);
        queue_req(REQ_REM_AT, 32'hffff_ffff, 4'd15);
        for (int k = 0; k < DEPTH; k++) begin
            case (k)
                0: word = 32'h7fff_ffff;
                1: word = 32'h8000_0000;
                2: word = 32'h0000_0000;
                3: word = 32'hffff_ffff;
                default: word = $urandom;
            endcase
            queue_req(k[0] ? REQ_INS_BACK : REQ_INS_FRONT, word, k[POS_W-1:0]);
        end
        queue_req(REQ_INS_FRONT, 32'h5555_aaaa, 4'd0);
        queue_req(REQ_READ, 32'h0, 4'd15);
        queue_req(REQ_READ, 32'h0, 4'd0);
        queue_req(REQ_REM_AT, 32'h0, 4'd15);
        queue_req(REQ_REM_AT, 32'h0, 4'd0);
        queue_req(REQ_READ, 32'h0, 4'd14);

        traffic_left = 0;
        traffic      = MIXED;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (traffic_left == 0) begin
                traffic      = traffic_t'($urandom_range(0, 2));
                traffic_left = $urandom_range(8, 40);
            end
            traffic_left--;
            case (traffic)
                FILL_UP:    ins_pct = 75;
                DRAIN_DOWN: ins_pct = 15;
                default:    ins_pct = 40;
            endcase
            if ($urandom_range(0, 99) < ins_pct) begin
                kind = $urandom_range(0, 1) ? REQ_INS_BACK : REQ_INS_FRONT;
            end else begin
                case ($urandom_range(0, 2))
                    0: kind = REQ_REM_LAST;
                    1: kind = REQ_REM_AT;
                    default: kind = REQ_READ;
                endcase
            end
            if (gen_count > 0 && $urandom_range(0, 9) < 8)
                pos = POS_W'($urandom_range(0, gen_count - 1));
            else
                pos = POS_W'($urandom_range(0, 15));
            queue_req(kind, pick_word(), pos);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_responses.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0 && expected_responses.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (pending_reqs.size() <= TAIL_ITEMS)
                tail_phase <= 1'b1;
            if (s_tvalid && s_tready)
                expected_responses.push_back(predict_response(offered));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
                    tx_gap   = $urandom_range(1, 19) - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    offered  = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered.kind;
                    s_tdata  <= {{(S_TDATA_W - VALUE_W - POS_W){1'b0}}, offered.pos,
                                 offered.word};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result ready with random stalls and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_tready  <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 15) == 0) begin
            rx_gap   = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            got = m_tdata;
            if (expected_responses.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = expected_responses.pop_front();
                if (got.rdata !== want.rdata)
                    report_mismatch("read_data", want.rdata, got.rdata);
                if (got.status !== want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.count !== want.count)
                    report_mismatch("count", want.count, got.count);
                if (got.empty !== want.empty)
                    report_mismatch("empty_res", want.empty, got.empty);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
